/* sv/key_set_store_macros.svh */
// Assertion macros shared by the key set store RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef KEY_SET_STORE_MACROS_SVH
`define KEY_SET_STORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key_set_store: assertion failed");

// Next-cycle implication, checked outside reset.
`define KSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key_set_store: assertion failed");

`endif

/* sv/kss_pkg.sv */
// Shared types for the key set store: control and status between the
// sequencer and the slot scan unit, and the operation codes. No dependencies.
`default_nettype none

package kss_pkg;

  // Operation codes carried on in_operation.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  // Per-cycle commands from the sequencer to the scan unit.
  typedef struct packed {
    logic start;  // clear the trackers for a new item
    logic check;  // a slot word is on the read data this cycle
  } kss_scan_ctl_t;

  // Scan results gathered over one pass of the store.
  typedef struct packed {
    logic hit;       // a valid slot holds the key
    logic has_free;  // at least one slot is free
  } kss_scan_sts_t;

endpackage

`default_nettype wire

/* sv/kss_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kss_ram #(
  parameter int Width = 33,
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/kss_scan.sv */
// Slot scan unit: one key comparator applied to one slot word per cycle,
// tracking the matching slot and the lowest free slot. Uses kss_pkg.
`default_nettype none

module kss_scan
  import kss_pkg::*;
#(
  parameter int AddrW = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire kss_scan_ctl_t    ctl,
  input  wire logic [32:0]      slot_word,   // {valid, key}
  input  wire logic [31:0]      key,
  input  wire logic [AddrW-1:0] slot_idx,
  output kss_scan_sts_t         sts,
  output logic      [AddrW-1:0] hit_idx,
  output logic      [AddrW-1:0] free_idx
);

  kss_scan_sts_t    sts_r, sts_nxt;
  logic [AddrW-1:0] hit_idx_r, hit_idx_nxt;
  logic [AddrW-1:0] free_idx_r, free_idx_nxt;
  logic             slot_valid;
  logic             key_match;

  assign slot_valid = slot_word[32];
  assign key_match  = (slot_word[31:0] == key);

  always_comb begin
    sts_nxt      = sts_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    if (ctl.start) begin
      sts_nxt = '0;
    end else if (ctl.check) begin
      if (slot_valid && key_match) begin
        sts_nxt.hit = 1'b1;
        hit_idx_nxt = slot_idx;
      end
      // Only the first free slot seen is kept, so adds fill from the bottom.
      if (!slot_valid && !sts_r.has_free) begin
        sts_nxt.has_free = 1'b1;
        free_idx_nxt     = slot_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sts_r <= '0;
    end else begin
      sts_r <= sts_nxt;
    end
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign sts      = sts_r;
  assign hit_idx  = hit_idx_r;
  assign free_idx = free_idx_r;

endmodule

`default_nettype wire

/* sv/key_set_store.sv */
// Key set store top level: sequencer, slot RAM, scan unit and result register.
// Depends on kss_pkg, kss_ram, kss_scan and key_set_store_macros.svh.
//
//   Channel | Direction | Handshake           | Payload
//   in      | input     | in_valid/in_ready   | in_operation, in_key
//   out     | output    | out_valid/out_ready | out_was_present, out_add_rejected,
//           |           |                     | out_member_count
//
// After reset a clearing pass marks every slot free; in_ready stays low until it
// ends. Each item then runs through scan, commit and delivery before the next
// in_ready: the single comparator reads one slot word per cycle from the slot RAM,
// then the commit step writes the slot back for an add or a remove and the
// delivery step moves the result into the output register.
// A result waiting on out_ready holds the next item at the delivery step only.
`default_nettype none

`include "key_set_store_macros.svh"

module key_set_store
  import kss_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic signed [31:0] in_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_was_present,
  output logic             out_add_rejected,
  output logic      [4:0]  out_member_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [CW-1:0] CAP_LAST = CW'(CAPACITY - 1);
  localparam logic [4:0]    CAP_LO   = 5'(CAPACITY);

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_COMMIT  = 5'b01000,
    ST_DELIVER = 5'b10000
  } kss_state_t;

  kss_state_t     state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  prev_idx_r;
  logic [1:0]     op_r;
  logic [31:0]    key_r;
  logic           res_present_r, res_present_nxt;
  logic           res_reject_r, res_reject_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_present_r;
  logic           out_reject_r;
  logic [4:0]     out_count_r;
  logic [CW+4:0]  count_wide;

  logic           in_xfer;
  logic           out_free;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [32:0]    ram_wdata;
  logic [32:0]    ram_rdata;

  kss_scan_ctl_t  scan_ctl;
  kss_scan_sts_t  scan_sts;
  logic [AW-1:0]  hit_idx;
  logic [AW-1:0]  free_idx;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign scan_ctl.start = in_xfer;
  assign scan_ctl.check = (state_r == ST_SCAN) && (cnt_r != '0);

  kss_ram #(
    .Width(33),
    .Depth(CAPACITY),
    .AddrW(AW)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  kss_scan #(
    .AddrW(AW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .slot_word(ram_rdata),
    .key      (key_r),
    .slot_idx (prev_idx_r),
    .sts      (scan_sts),
    .hit_idx  (hit_idx),
    .free_idx (free_idx)
  );

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    count_nxt       = count_r;
    res_present_nxt = res_present_r;
    res_reject_nxt  = res_reject_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    ram_we          = 1'b0;
    ram_waddr       = cnt_r[AW-1:0];
    ram_wdata       = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CAP_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Reads are issued for counts below CAPACITY; the last word is
        // checked in the cycle the count reaches CAPACITY.
        if (cnt_r == CAP_C) begin
          state_nxt = ST_COMMIT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_COMMIT: begin
        res_present_nxt = scan_sts.hit;
        res_reject_nxt  = 1'b0;
        case (op_r)
          OP_ADD: begin
            if (!scan_sts.hit) begin
              if (scan_sts.has_free) begin
                ram_we    = 1'b1;
                ram_waddr = free_idx;
                ram_wdata = {1'b1, key_r};
                count_nxt = count_r + CW'(1);
              end else begin
                res_reject_nxt = 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (scan_sts.hit) begin
              ram_we    = 1'b1;
              ram_waddr = hit_idx;
              ram_wdata = {1'b0, key_r};
              count_nxt = count_r - CW'(1);
            end
          end
          default: begin
            // Look-up and the unused code change nothing.
          end
        endcase
        state_nxt = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  assign count_wide = {5'b0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prev_idx_r    <= cnt_r[AW-1:0];
    res_present_r <= res_present_nxt;
    res_reject_r  <= res_reject_nxt;
    if (in_xfer) begin
      op_r  <= in_operation;
      key_r <= in_key;
    end
    if ((state_r == ST_DELIVER) && out_free) begin
      out_present_r <= res_present_r;
      out_reject_r  <= res_reject_r;
      out_count_r   <= count_wide[4:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_was_present  = out_present_r;
  assign out_add_rejected = out_reject_r;
  assign out_member_count = out_count_r;

  // The member count can never pass the number of slots.
  `KSS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CAP_C)
  // A rejected add means the key was absent and the store was full.
  `KSS_ASSERT_IMP(a_reject_absent, out_valid_r && out_reject_r, !out_present_r)
  `KSS_ASSERT_IMP(a_reject_full, out_valid_r && out_reject_r, out_count_r == CAP_LO)
  // An accepted item keeps the input closed until its result is delivered.
  `KSS_ASSERT_NXT(a_busy_after_xfer, in_xfer, !in_ready && (state_r == ST_SCAN))
  // A result is only released from the delivery step.
  `KSS_ASSERT_NXT(a_out_source, !out_valid_r && (state_r != ST_DELIVER), !out_valid_r)

endmodule

`default_nettype wire
